// ===== hdl/fqc_pkg.sv =====
package fqc_pkg;

  // Number of slots in the queue.
  localparam int QUEUE_DEPTH = 16;

  // Field widths of the items.
  localparam int KEY_W = 50;
  localparam int AGE_W = 8;
  localparam int OCC_W = 5;

  // Width of the internal entry counter, wide enough to hold the depth itself.
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ACT_ARRIVE  = 2'd0,
    ACT_DEPART  = 2'd1,
    ACT_ABANDON = 2'd2,
    ACT_QUERY   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]       action;
    logic [KEY_W-1:0] entry_key;
    logic [AGE_W-1:0] entry_age;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             found;
    logic [KEY_W-1:0] head_key;
    logic [AGE_W-1:0] head_age;
    logic [OCC_W-1:0] occupancy;
  } out_item_t;

  // Contents of one slot as seen by its neighbor.
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [AGE_W-1:0] age;
  } slot_t;

  // Action broadcast to every cell in the row.
  typedef struct packed {
    logic             en;
    action_t          op;
    logic             nonempty;
    logic [KEY_W-1:0] key;
    logic [AGE_W-1:0] age;
  } cell_ctrl_t;

endpackage

// ===== hdl/fqc_cell.sv =====
module fqc_cell
  import fqc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  logic       prev_valid,
  input  logic       hit_in,
  input  slot_t      up_slot,
  output logic       hit_out,
  output slot_t      slot
);

  logic             valid_r, valid_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [AGE_W-1:0] age_r, age_nxt;
  logic             match;
  logic             shift;
  logic             write;

  // Compare the broadcast key and pass the first-match flag along the row.
  assign match   = valid_r && (key_r == ctrl.key);
  assign hit_out = hit_in | match;

  // A removal at or ahead of this slot pulls the next entry forward.
  assign shift = ctrl.en &&
                 (((ctrl.op == ACT_DEPART) && ctrl.nonempty) ||
                  ((ctrl.op == ACT_ABANDON) && hit_out));

  // An arriving entry lands in the first free slot; entries stay contiguous.
  assign write = ctrl.en && (ctrl.op == ACT_ARRIVE) && !valid_r && prev_valid;

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    age_nxt   = age_r;
    if (shift) begin
      valid_nxt = up_slot.valid;
      key_nxt   = up_slot.key;
      age_nxt   = up_slot.age;
    end else if (write) begin
      valid_nxt = 1'b1;
      key_nxt   = ctrl.key;
      age_nxt   = ctrl.age;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    age_r <= age_nxt;
  end

  assign slot.valid = valid_r;
  assign slot.key   = key_r;
  assign slot.age   = age_r;

endmodule

// ===== hdl/fifo_queue_with_cancel_by_key_unit.sv =====
// Keyed FIFO waiting queue of QUEUE_DEPTH entries, built as a row of slot cells
// with the head in cell 0. Each item is one action (arrive, depart, abandon by
// key, query) and yields exactly one result item, registered at the output in
// the cycle after the item is accepted. One item is taken in every unstalled
// cycle: the key is compared in all cells at once, the first match is found by
// a flag that ripples along the row, and removal closes the gap by each later
// cell taking its neighbor's entry at the same clock edge. The input stalls
// only while a finished result waits to be taken. No clearing pass after reset.
module fifo_queue_with_cancel_by_key_unit
  import fqc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic                  accept;
  cell_ctrl_t            ctrl;
  slot_t                 slots   [QUEUE_DEPTH];
  slot_t                 up_slots[QUEUE_DEPTH];
  logic [QUEUE_DEPTH:0]  hit;
  logic [QUEUE_DEPTH-1:0] prev_valid;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_r, out_nxt;
  logic                  empty;
  logic                  full;

  // Input is blocked only while a result waits to be taken.
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign empty = !slots[0].valid;
  assign full  = slots[QUEUE_DEPTH-1].valid;

  // Broadcast of the current action to all cells.
  assign ctrl.en       = accept;
  assign ctrl.op       = action_t'(in_item.action);
  assign ctrl.nonempty = !empty;
  assign ctrl.key      = in_item.entry_key;
  assign ctrl.age      = in_item.entry_age;

  assign hit[0]        = 1'b0;
  assign prev_valid[0] = 1'b1;

  // Row of slot cells, each linked to its neighbors.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign up_slots[i] = '0;
    end else begin : g_mid
      assign up_slots[i]     = slots[i+1];
      assign prev_valid[i+1] = slots[i].valid;
    end

    fqc_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .prev_valid (prev_valid[i]),
      .hit_in     (hit[i]),
      .up_slot    (up_slots[i]),
      .hit_out    (hit[i+1]),
      .slot       (slots[i])
    );
  end

  // Result and entry count for the accepted action.
  always_comb begin
    count_nxt         = count_r;
    out_valid_nxt     = out_valid_r && out_stall;
    out_nxt           = out_r;
    if (accept) begin
      out_valid_nxt     = 1'b1;
      out_nxt.status    = ST_DONE;
      out_nxt.found     = 1'b0;
      out_nxt.head_key  = '0;
      out_nxt.head_age  = '0;
      unique case (action_t'(in_item.action))
        ACT_ARRIVE: begin
          if (full) begin
            out_nxt.status = ST_FULL;
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
        ACT_DEPART: begin
          if (empty) begin
            out_nxt.status = ST_EMPTY;
          end else begin
            out_nxt.found    = 1'b1;
            out_nxt.head_key = slots[0].key;
            out_nxt.head_age = slots[0].age;
            count_nxt        = count_r - CNT_W'(1);
          end
        end
        ACT_ABANDON: begin
          if (empty) begin
            out_nxt.status = ST_EMPTY;
          end else if (hit[QUEUE_DEPTH]) begin
            out_nxt.found = 1'b1;
            count_nxt     = count_r - CNT_W'(1);
          end else begin
            out_nxt.status = ST_NOTFOUND;
          end
        end
        ACT_QUERY: begin
          out_nxt.found = hit[QUEUE_DEPTH];
        end
        default: begin
          out_nxt.status = ST_DONE;
        end
      endcase
      out_nxt.occupancy = OCC_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ===== hdl/fqc_checker.sv =====
module fqc_checker
  import fqc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // Every accepted item yields a result on the next cycle.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted item produced no result");

  // An empty report leaves nothing in the queue and removes nothing.
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status == ST_EMPTY) |->
      (out_item.occupancy == '0) && !out_item.found)
    else $error("empty status with entries or a hit");

  // A full report means every slot is taken.
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status == ST_FULL) |->
      (out_item.occupancy == OCC_W'(QUEUE_DEPTH)))
    else $error("full status with a free slot");

  // A head key is only returned by a successful depart.
  a_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.head_key != '0) |->
      out_item.found && (out_item.status == ST_DONE))
    else $error("head key returned without a departure");

endmodule

bind fifo_queue_with_cancel_by_key_unit fqc_checker u_fqc_checker (.*);
